[hw/rtl/hmng_pkg.sv]
// Shared types and constants of the heightmap mesh normal generator.
// Used by the controller, the datapath, the normalizer and the top level.
package hmng_pkg;

    localparam int MAX_SIDE   = 64;
    localparam int COORD_W    = $clog2(MAX_SIDE);
    localparam int IDX_W      = 2 * COORD_W;
    localparam int CNT_W      = IDX_W + 1;
    localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
    localparam int GRID_W     = 7;
    localparam int SCALE_W    = 10;
    localparam int HGT_W      = 16;
    localparam int Y_W        = HGT_W + SCALE_W;
    localparam int HM_W       = 2 * COORD_W + Y_W;
    localparam int NRM_W      = 16;
    localparam int SUM_W      = 19;
    localparam int VEC_W      = Y_W + 1;
    localparam int PROD_W     = 2 * VEC_W;
    localparam int SQ_W       = PROD_W + 2;
    localparam int LEN_W      = SQ_W / 2;
    localparam int QUO_W      = NRM_W + 1;
    localparam int REM_W      = LEN_W + 1 + QUO_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 88;

    localparam logic [GRID_W-1:0]    SIDE_MIN  = GRID_W'(2);
    localparam logic [GRID_W-1:0]    SIDE_MAX  = GRID_W'(MAX_SIDE);
    localparam logic [GRID_W-1:0]    GRID_RST  = GRID_W'(64);
    localparam logic [SCALE_W-1:0]   SCALE_RST = SCALE_W'(200);
    // y component of every face cross product: one grid step squared, in Q.16
    localparam logic signed [VEC_W-1:0] FACE_Y = VEC_W'(65536);
    localparam logic [QUO_W-1:0]     Q_POS_MAX = QUO_W'(32767);
    localparam logic [QUO_W-1:0]     Q_NEG_MAX = QUO_W'(32768);

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = CFG_IDX_W'(1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_OUT,
        ST_CLR,
        ST_F_RD,
        ST_F_NSTART,
        ST_F_NWAIT,
        ST_F_ACC_RD,
        ST_F_ACC_WR,
        ST_V_RD,
        ST_V_NSTART,
        ST_V_NWAIT
    } t_state;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SQ,
        N_SQRT,
        N_DINIT,
        N_DIV
    } t_nstate;

    typedef enum logic [1:0] {
        C_LB,
        C_RB,
        C_LT,
        C_RT
    } t_corner;

    typedef enum logic [1:0] {
        NS_FACE0,
        NS_FACE1,
        NS_VERTEX
    } t_nsrc;

    typedef struct packed {
        logic    cfg_write;
        logic    ld_write;
        logic    rd_issue;
        logic    rd_ready;
        logic    out_load;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    clr_write;
        logic    cell_init;
        logic    cell_adv;
        logic    h_issue;
        t_corner h_sel;
        logic    h_cap;
        logic    norm_start;
        t_nsrc   norm_src;
        logic    acc_rd;
        logic    acc_wr;
        logic    acc_face;
        logic [1:0] acc_k;
        logic    vtx_rd;
        logic    vtx_wr;
    } t_cmd;

    typedef struct packed {
        logic ld_last;
        logic cnt_last;
        logic cell_last_j;
        logic cell_last_i;
        logic norm_done;
    } t_stat;

endpackage

[hw/rtl/heightmap_mesh_normal_generator_core.sv]
// Top level of the heightmap mesh normal generator: stream ports and the
// configuration channel around hmng_ctrl and hmng_dp. Depends on hmng_pkg.
//
// Load requests (tuser = 0) are taken one per cycle while no read result
// waits on the output, and store height_scale * height for the next vertex
// in row-major order. The load that completes the grid of n*n samples
// (n = grid_size clamped to 2..64) starts the normal pass, during which
// neither stream input nor configuration requests are taken: a clear sweep
// over the n*n entries of the face-sum memory, a face step for each of the
// (n-1)^2 grid cells, then a vertex step for each vertex. The pass time is
// set by the shared normalizer, which computes the squares, the square root
// and each of three component divisions in turn. A read request (tuser = 1)
// returns one result whose tuser flags a valid vertex; a read before the
// pass is done or beyond n*n returns zeros with the flag low. A configuration
// write to grid_size or height_scale restarts loading, and a pending
// configuration write holds off stream requests.
module heightmap_mesh_normal_generator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [15:0] height, [27:16] vertex_index, [31:28] zero
    input  logic [hmng_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // [0] operation
    input  logic                                 i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [5:0] pos_row, [31:6] pos_height, [37:32] pos_col, [53:38] normal_x,
    // [69:54] normal_y, [85:70] normal_z, [87:86] zero
    output logic [hmng_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // [0] valid_res
    output logic                                 o_m_axis_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hmng_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hmng_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import hmng_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic [COORD_W-1:0]      w_row, w_col;
    logic [Y_W-1:0]          w_pos_height;
    logic signed [NRM_W-1:0] w_nx, w_ny, w_nz;

    hmng_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_op     (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    hmng_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_height       (i_s_axis_tdata[HGT_W-1:0]),
        .i_vertex_index (i_s_axis_tdata[HGT_W +: IDX_W]),
        .o_valid_res    (o_m_axis_tuser),
        .o_pos_row      (w_row),
        .o_pos_height   (w_pos_height),
        .o_pos_col      (w_col),
        .o_normal_x     (w_nx),
        .o_normal_y     (w_ny),
        .o_normal_z     (w_nz)
    );

    assign o_m_axis_tdata = {2'b00, w_nz, w_ny, w_nx, w_col, w_pos_height, w_row};

endmodule

[hw/rtl/hmng_norm.sv]
// Iterative vector normalizer: sum of squares, bit-pair square root, then
// one restoring division per component to Q1.15. Depends on hmng_pkg.
module hmng_norm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [hmng_pkg::VEC_W-1:0] i_vec [3],
    output logic                              o_done,
    output logic signed [hmng_pkg::NRM_W-1:0] o_nrm [3]
);
    import hmng_pkg::*;

    t_nstate r_state, n_state;
    logic [VEC_W-1:0]  r_mag [3];
    logic              r_neg [3];
    logic [PROD_W-1:0] r_prod;
    logic [SQ_W-1:0]   r_x, r_r, r_b;
    logic [LEN_W-1:0]  r_len;
    logic [REM_W-1:0]  r_rem, r_dsh;
    logic [QUO_W-1:0]  r_q;
    logic [1:0]        r_k;
    logic [4:0]        r_it;
    logic              r_done;
    logic signed [NRM_W-1:0] r_res [3];

    logic [VEC_W-1:0]  w_mag;
    logic [SQ_W-1:0]   w_t;
    logic [SQ_W-1:0]   w_r_next;
    logic              w_ge;
    logic [QUO_W-1:0]  w_q_next;
    logic [QUO_W-1:0]  w_lim;
    logic [QUO_W-1:0]  w_neg_q;

    always_comb begin
        case (r_k)
            2'd0:    w_mag = r_mag[0];
            2'd1:    w_mag = r_mag[1];
            2'd2:    w_mag = r_mag[2];
            default: w_mag = '0;
        endcase
    end

    assign w_t      = r_r + r_b;
    assign w_r_next = (r_x >= w_t) ? ((r_r >> 1) + r_b) : (r_r >> 1);
    assign w_ge     = (r_rem >= r_dsh);
    assign w_q_next = {r_q[QUO_W-2:0], w_ge};

    // round-half-away result saturated to the Q1.15 range
    always_comb begin
        w_lim   = '0;
        w_neg_q = '0;
        if (r_neg[r_k]) begin
            w_lim   = (w_q_next > Q_NEG_MAX) ? Q_NEG_MAX : w_q_next;
            w_neg_q = QUO_W'(0) - w_lim;
        end else begin
            w_lim   = (w_q_next > Q_POS_MAX) ? Q_POS_MAX : w_q_next;
            w_neg_q = w_lim;
        end
        if (r_len == '0) begin
            w_neg_q = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            N_IDLE:  if (i_start) n_state = N_SQ;
            N_SQ:    if (r_k == 2'd3) n_state = N_SQRT;
            N_SQRT:  if (r_b == SQ_W'(1)) n_state = N_DINIT;
            N_DINIT: n_state = N_DIV;
            N_DIV: begin
                if (r_it == '0) begin
                    n_state = (r_k == 2'd2) ? N_IDLE : N_DINIT;
                end
            end
            default: n_state = N_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == N_DIV) && (r_it == '0) && (r_k == 2'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    for (int k = 0; k < 3; k++) begin
                        r_neg[k] <= i_vec[k][VEC_W-1];
                        r_mag[k] <= i_vec[k][VEC_W-1] ? VEC_W'(-i_vec[k]) : VEC_W'(i_vec[k]);
                    end
                    r_k <= '0;
                end
            end
            N_SQ: begin
                r_prod <= w_mag * w_mag;
                r_x    <= (r_k == 2'd0) ? '0 : r_x + SQ_W'(r_prod);
                r_k    <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_r <= '0;
                    r_b <= SQ_W'(1) << (SQ_W - 2);
                    r_k <= '0;
                end
            end
            N_SQRT: begin
                if (r_x >= w_t) begin
                    r_x <= r_x - w_t;
                end
                r_r <= w_r_next;
                r_b <= r_b >> 2;
                if (r_b == SQ_W'(1)) begin
                    r_len <= w_r_next[LEN_W-1:0];
                end
            end
            N_DINIT: begin
                r_rem <= REM_W'({w_mag, {NRM_W{1'b0}}}) + REM_W'(r_len);
                r_dsh <= REM_W'({r_len, 1'b0}) << (QUO_W - 1);
                r_q   <= '0;
                r_it  <= 5'(QUO_W - 1);
            end
            N_DIV: begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh <= r_dsh >> 1;
                r_q   <= w_q_next;
                r_it  <= r_it - 5'd1;
                if (r_it == '0) begin
                    r_res[r_k] <= w_neg_q[NRM_W-1:0];
                    r_k        <= r_k + 2'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_nrm  = r_res;

endmodule

[hw/rtl/hmng_dp.sv]
// Datapath: configuration registers, counters, height / sum / unit-normal
// memories, result register and the normalizer. Depends on hmng_pkg, hmng_norm.
module hmng_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hmng_pkg::t_cmd                      i_cmd,
    output hmng_pkg::t_stat                     o_stat,
    input  logic [hmng_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hmng_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [hmng_pkg::HGT_W-1:0]          i_height,
    input  logic [hmng_pkg::IDX_W-1:0]          i_vertex_index,
    output logic                                o_valid_res,
    output logic [hmng_pkg::COORD_W-1:0]        o_pos_row,
    output logic [hmng_pkg::Y_W-1:0]            o_pos_height,
    output logic [hmng_pkg::COORD_W-1:0]        o_pos_col,
    output logic signed [hmng_pkg::NRM_W-1:0]   o_normal_x,
    output logic signed [hmng_pkg::NRM_W-1:0]   o_normal_y,
    output logic signed [hmng_pkg::NRM_W-1:0]   o_normal_z
);
    import hmng_pkg::*;

    logic [GRID_W-1:0]  r_grid;
    logic [SCALE_W-1:0] r_scale;
    logic [GRID_W-1:0]  w_side;
    logic [CNT_W-1:0]   w_total;

    logic [IDX_W-1:0]   r_ld_cnt;
    logic [COORD_W-1:0] r_ld_row, r_ld_col;
    logic [IDX_W-1:0]   r_cnt;
    logic [COORD_W-1:0] r_ci, r_cj;
    logic [IDX_W-1:0]   r_lb;

    logic [HM_W-1:0]    r_hmem [DEPTH];
    logic [HM_W-1:0]    r_hq;
    logic [Y_W-1:0]     w_y;
    logic [IDX_W-1:0]   w_h_addr, w_corner_addr;
    t_corner            r_cap_sel;
    logic [Y_W-1:0]     r_y [4];

    logic [3*SUM_W-1:0] r_smem [DEPTH];
    logic [3*SUM_W-1:0] r_sq, w_sum_new, w_s_wdata;
    logic [IDX_W-1:0]   r_sum_addr, w_s_raddr, w_acc_addr, w_s_waddr;
    logic               w_s_we;

    logic [3*NRM_W-1:0] r_umem [DEPTH];
    logic [3*NRM_W-1:0] r_uq;
    logic               r_rd_ok;

    logic signed [VEC_W-1:0] w_vec [3];
    logic signed [NRM_W-1:0] w_nrm [3];
    logic                    w_done;

    logic [IDX_W-1:0] w_lt, w_rb, w_rt;

    // side length clamped to the supported range
    assign w_side  = (r_grid < SIDE_MIN) ? SIDE_MIN : ((r_grid > SIDE_MAX) ? SIDE_MAX : r_grid);
    assign w_total = CNT_W'(w_side) * CNT_W'(w_side);
    assign w_y     = Y_W'(r_scale) * Y_W'(i_height);

    assign w_lt = r_lb + IDX_W'(1);
    assign w_rb = r_lb + IDX_W'(w_side);
    assign w_rt = w_rb + IDX_W'(1);

    assign o_stat.ld_last     = ({1'b0, r_ld_cnt} == w_total - CNT_W'(1));
    assign o_stat.cnt_last    = ({1'b0, r_cnt} == w_total - CNT_W'(1));
    assign o_stat.cell_last_j = ({1'b0, r_cj} == w_side - GRID_W'(2));
    assign o_stat.cell_last_i = ({1'b0, r_ci} == w_side - GRID_W'(2));
    assign o_stat.norm_done   = w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid   <= GRID_RST;
            r_scale  <= SCALE_RST;
            r_ld_cnt <= '0;
            r_ld_row <= '0;
            r_ld_col <= '0;
        end else if (i_cmd.cfg_write) begin
            case (i_cfg_index)
                CFG_GRID_SIZE:    r_grid  <= i_cfg_data[GRID_W-1:0];
                CFG_HEIGHT_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
            r_ld_cnt <= '0;
            r_ld_row <= '0;
            r_ld_col <= '0;
        end else if (i_cmd.ld_write) begin
            if (o_stat.ld_last) begin
                r_ld_cnt <= '0;
                r_ld_row <= '0;
                r_ld_col <= '0;
            end else begin
                r_ld_cnt <= r_ld_cnt + IDX_W'(1);
                if ({1'b0, r_ld_col} == w_side - GRID_W'(1)) begin
                    r_ld_col <= '0;
                    r_ld_row <= r_ld_row + COORD_W'(1);
                end else begin
                    r_ld_col <= r_ld_col + COORD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + IDX_W'(1);
        end
        if (i_cmd.cell_init) begin
            r_ci <= '0;
            r_cj <= '0;
            r_lb <= '0;
        end else if (i_cmd.cell_adv) begin
            if (o_stat.cell_last_j) begin
                r_cj <= '0;
                r_ci <= r_ci + COORD_W'(1);
                r_lb <= r_lb + IDX_W'(2);
            end else begin
                r_cj <= r_cj + COORD_W'(1);
                r_lb <= r_lb + IDX_W'(1);
            end
        end
    end

    // height memory: {row, col, scaled height}
    always_comb begin
        case (i_cmd.h_sel)
            C_LB:    w_corner_addr = r_lb;
            C_RB:    w_corner_addr = w_rb;
            C_LT:    w_corner_addr = w_lt;
            C_RT:    w_corner_addr = w_rt;
            default: w_corner_addr = r_lb;
        endcase
    end
    assign w_h_addr = i_cmd.rd_issue ? i_vertex_index : w_corner_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_write) begin
            r_hmem[r_ld_cnt] <= {r_ld_row, r_ld_col, w_y};
        end
        if (i_cmd.h_issue || i_cmd.rd_issue) begin
            r_hq <= r_hmem[w_h_addr];
        end
        if (i_cmd.h_issue) begin
            r_cap_sel <= i_cmd.h_sel;
        end
        if (i_cmd.h_cap) begin
            r_y[r_cap_sel] <= r_hq[Y_W-1:0];
        end
    end

    // face corners: (lb, rb, lt) then (lt, rb, rt)
    always_comb begin
        case ({i_cmd.acc_face, i_cmd.acc_k})
            3'b000:  w_acc_addr = r_lb;
            3'b001:  w_acc_addr = w_rb;
            3'b010:  w_acc_addr = w_lt;
            3'b100:  w_acc_addr = w_lt;
            3'b101:  w_acc_addr = w_rb;
            3'b110:  w_acc_addr = w_rt;
            default: w_acc_addr = r_lb;
        endcase
    end
    assign w_s_raddr = i_cmd.acc_rd ? w_acc_addr : r_cnt;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum_new[k*SUM_W +: SUM_W] = r_sq[k*SUM_W +: SUM_W] + SUM_W'(w_nrm[k]);
        end
    end
    assign w_s_we    = i_cmd.clr_write || i_cmd.acc_wr;
    assign w_s_waddr = i_cmd.clr_write ? r_cnt : r_sum_addr;
    assign w_s_wdata = i_cmd.clr_write ? '0 : w_sum_new;

    always_ff @(posedge i_clk) begin
        if (w_s_we) begin
            r_smem[w_s_waddr] <= w_s_wdata;
        end
        if (i_cmd.acc_rd || i_cmd.vtx_rd) begin
            r_sq <= r_smem[w_s_raddr];
        end
        if (i_cmd.acc_rd) begin
            r_sum_addr <= w_acc_addr;
        end
    end

    always_comb begin
        w_vec[1] = FACE_Y;
        case (i_cmd.norm_src)
            NS_FACE0: begin
                w_vec[0] = $signed({1'b0, r_y[C_LB]}) - $signed({1'b0, r_y[C_RB]});
                w_vec[2] = $signed({1'b0, r_y[C_LB]}) - $signed({1'b0, r_y[C_LT]});
            end
            NS_FACE1: begin
                w_vec[0] = $signed({1'b0, r_y[C_LT]}) - $signed({1'b0, r_y[C_RT]});
                w_vec[2] = $signed({1'b0, r_y[C_RB]}) - $signed({1'b0, r_y[C_RT]});
            end
            NS_VERTEX: begin
                w_vec[0] = VEC_W'($signed(r_sq[0*SUM_W +: SUM_W]));
                w_vec[1] = VEC_W'($signed(r_sq[1*SUM_W +: SUM_W]));
                w_vec[2] = VEC_W'($signed(r_sq[2*SUM_W +: SUM_W]));
            end
            default: begin
                w_vec[0] = '0;
                w_vec[2] = '0;
            end
        endcase
    end

    hmng_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.norm_start),
        .i_vec   (w_vec),
        .o_done  (w_done),
        .o_nrm   (w_nrm)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.vtx_wr) begin
            r_umem[r_cnt] <= {w_nrm[2], w_nrm[1], w_nrm[0]};
        end
        if (i_cmd.rd_issue) begin
            r_uq    <= r_umem[i_vertex_index];
            r_rd_ok <= i_cmd.rd_ready && ({1'b0, i_vertex_index} < w_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_valid_res  <= r_rd_ok;
            o_pos_row    <= r_rd_ok ? r_hq[HM_W-1 -: COORD_W] : '0;
            o_pos_col    <= r_rd_ok ? r_hq[Y_W +: COORD_W] : '0;
            o_pos_height <= r_rd_ok ? r_hq[Y_W-1:0] : '0;
            o_normal_x   <= r_rd_ok ? r_uq[0*NRM_W +: NRM_W] : '0;
            o_normal_y   <= r_rd_ok ? r_uq[1*NRM_W +: NRM_W] : '0;
            o_normal_z   <= r_rd_ok ? r_uq[2*NRM_W +: NRM_W] : '0;
        end
    end

endmodule

[hw/rtl/hmng_ctrl.sv]
// Controller: request handshakes, normals-ready flag and the sequencer of
// the clear, face and vertex passes. Depends on hmng_pkg.
module hmng_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_op,
    output logic                           o_in_ready,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    input  logic                           i_cfg_valid,
    input  logic [hmng_pkg::CFG_IDX_W-1:0] i_cfg_index,
    output logic                           o_cfg_ready,
    output hmng_pkg::t_cmd                 o_cmd,
    input  hmng_pkg::t_stat                i_stat
);
    import hmng_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       r_face, n_face;
    logic       r_ready, n_ready;
    logic       r_out_valid, n_out_valid;
    logic       w_in_acc, w_cfg_acc, w_cfg_hit;

    // hold stream requests while busy, while a read result is pending or while a configuration write is pending
    assign o_in_ready  = (r_state == ST_IDLE) && !r_out_valid && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_cfg_hit   = w_cfg_acc && (i_cfg_index inside {CFG_GRID_SIZE, CFG_HEIGHT_SCALE});

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_face      = r_face;
        n_ready     = r_ready;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (w_cfg_hit) n_ready = 1'b0;
                if (w_in_acc) begin
                    if (i_in_op == OP_READ) begin
                        n_state = ST_RD_OUT;
                    end else begin
                        n_ready = 1'b0;
                        if (i_stat.ld_last) n_state = ST_CLR;
                    end
                end
            end
            ST_RD_OUT: begin
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_CLR: begin
                if (i_stat.cnt_last) begin
                    n_state = ST_F_RD;
                    n_step  = '0;
                    n_face  = 1'b0;
                end
            end
            ST_F_RD: begin
                n_step = r_step + 3'd1;
                if (r_step == 3'd4) n_state = ST_F_NSTART;
            end
            ST_F_NSTART: n_state = ST_F_NWAIT;
            ST_F_NWAIT: begin
                if (i_stat.norm_done) begin
                    n_state = ST_F_ACC_RD;
                    n_step  = '0;
                end
            end
            ST_F_ACC_RD: n_state = ST_F_ACC_WR;
            ST_F_ACC_WR: begin
                if (r_step == 3'd2) begin
                    if (!r_face) begin
                        n_face  = 1'b1;
                        n_state = ST_F_NSTART;
                    end else if (i_stat.cell_last_j && i_stat.cell_last_i) begin
                        n_state = ST_V_RD;
                    end else begin
                        n_state = ST_F_RD;
                        n_step  = '0;
                        n_face  = 1'b0;
                    end
                end else begin
                    n_step  = r_step + 3'd1;
                    n_state = ST_F_ACC_RD;
                end
            end
            ST_V_RD:     n_state = ST_V_NSTART;
            ST_V_NSTART: n_state = ST_V_NWAIT;
            ST_V_NWAIT: begin
                if (i_stat.norm_done) begin
                    if (i_stat.cnt_last) begin
                        n_ready = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_V_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.rd_ready = r_ready;
        o_cmd.h_sel    = C_LB;
        o_cmd.norm_src = NS_VERTEX;
        case (r_state)
            ST_IDLE: begin
                o_cmd.cfg_write = w_cfg_hit;
                if (w_in_acc) begin
                    if (i_in_op == OP_READ) begin
                        o_cmd.rd_issue = 1'b1;
                    end else begin
                        o_cmd.ld_write = 1'b1;
                        o_cmd.cnt_clr  = i_stat.ld_last;
                    end
                end
            end
            ST_RD_OUT: o_cmd.out_load = 1'b1;
            ST_CLR: begin
                o_cmd.clr_write = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
                o_cmd.cell_init = i_stat.cnt_last;
            end
            ST_F_RD: begin
                // issue four corner reads, capture each in the step after its issue
                o_cmd.h_issue = (r_step != 3'd4);
                o_cmd.h_sel   = t_corner'(r_step[1:0]);
                o_cmd.h_cap   = (r_step != 3'd0);
            end
            ST_F_NSTART: begin
                o_cmd.norm_start = 1'b1;
                o_cmd.norm_src   = r_face ? NS_FACE1 : NS_FACE0;
            end
            ST_F_ACC_RD: begin
                o_cmd.acc_rd   = 1'b1;
                o_cmd.acc_face = r_face;
                o_cmd.acc_k    = r_step[1:0];
            end
            ST_F_ACC_WR: begin
                o_cmd.acc_wr = 1'b1;
                if (r_step == 3'd2 && r_face) begin
                    if (i_stat.cell_last_j && i_stat.cell_last_i) begin
                        o_cmd.cnt_clr = 1'b1;
                    end else begin
                        o_cmd.cell_adv = 1'b1;
                    end
                end
            end
            ST_V_RD: o_cmd.vtx_rd = 1'b1;
            ST_V_NSTART: begin
                o_cmd.norm_start = 1'b1;
                o_cmd.norm_src   = NS_VERTEX;
            end
            ST_V_NWAIT: begin
                o_cmd.vtx_wr  = i_stat.norm_done;
                o_cmd.cnt_inc = i_stat.norm_done;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_face      <= 1'b0;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_face      <= n_face;
            r_ready     <= n_ready;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
